FILE: src/sacl_pkg.sv
package sacl_pkg;

  // Fixed field widths of the lookup.
  localparam int ADDR_BITS = 32;
  localparam int AGE_W     = 32;
  localparam int COUNT_W   = 40;
  localparam int OUT_WAY_W = 2;

  // Default geometry.
  localparam int DEF_WAYS        = 4;
  localparam int DEF_SETS        = 256;
  localparam int DEF_BLOCK_BYTES = 64;

  // Floor of log2, evaluated at elaboration.
  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  // Keeps a width at least one bit wide.
  function automatic int max1(input int v);
    return (v > 0) ? v : 1;
  endfunction

  // Default row layout: per way one valid bit, one tag and one age.
  localparam int DEF_ADDR_W = max1(flog2(DEF_SETS));
  localparam int DEF_ROW_W  = DEF_WAYS * (1 + ADDR_BITS - flog2(DEF_SETS)
                              - flog2(DEF_BLOCK_BYTES) + AGE_W);

endpackage

FILE: src/sacl_set_ram.sv
module sacl_set_ram
  import sacl_pkg::*;
#(
  parameter int ADDR_W = DEF_ADDR_W,
  parameter int ROW_W  = DEF_ROW_W
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ROW_W-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/sacl_victim_scan.sv
module sacl_victim_scan
  import sacl_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [WAYS-1:0][AGE_W-1:0]       ages,
  output logic                             done,
  output logic [max1($clog2(WAYS))-1:0]    victim
);

  localparam int WAY_W = max1($clog2(WAYS));
  localparam int CNT_W = $clog2(WAYS + 1);

  logic             busy;
  logic [CNT_W-1:0] idx;
  logic [AGE_W-1:0] best;
  logic [WAY_W-1:0] best_way;

  assign done   = busy && (idx == CNT_W'(WAYS));
  assign victim = best_way;

  // Walk the ways one per cycle; a strictly greater age takes over, so the
  // lowest way wins a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      idx      <= CNT_W'(1);
      best     <= ages[0];
      best_way <= '0;
    end else if (busy) begin
      if (idx == CNT_W'(WAYS)) begin
        busy <= 1'b0;
      end else begin
        if (ages[idx[WAY_W-1:0]] > best) begin
          best     <= ages[idx[WAY_W-1:0]];
          best_way <= idx[WAY_W-1:0];
        end
        idx <= idx + CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/set_assoc_cache_lru_lookup_core.sv
// Set-associative cache lookup with least-recently-used replacement. Each
// item is one 32-bit byte address; the result tells whether a valid way of
// the addressed set held the tag, which way hit or was refilled, and the
// saturating running totals of hits and misses including this access. The
// set state (valid bit, tag and 32-bit age of every way) lives in one
// synchronous RAM with one row per set. After reset a clearing pass writes
// every row to zero, one row per cycle, while no item is taken. One item is
// in work at a time: a hit passes through row read, tag compare and row
// write before the next acceptance; a miss adds a victim search between
// compare and write, which compares one way's age per cycle. A finished
// result waits in the output register while the next item is accepted; its
// write-back waits only if that result is still held.
module set_assoc_cache_lru_lookup_core
  import sacl_pkg::*;
#(
  parameter int WAYS        = DEF_WAYS,
  parameter int SETS        = DEF_SETS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_BITS-1:0]  address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [OUT_WAY_W-1:0]  way,
  output logic [COUNT_W-1:0]    hit_count,
  output logic [COUNT_W-1:0]    miss_count
);

  localparam int OFF_W     = flog2(BLOCK_BYTES);
  localparam int IDX_W     = flog2(SETS);
  localparam int ADDR_W    = max1(IDX_W);
  localparam int TAG_SHIFT = OFF_W + IDX_W;
  localparam int TAG_W     = ADDR_BITS - TAG_SHIFT;
  localparam int WAY_W     = max1($clog2(WAYS));
  localparam int ROW_W     = WAYS * (1 + TAG_W + AGE_W);
  localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'((64'd1 << IDX_W) - 64'd1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOK   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]  clear_addr;
  logic [ADDR_W-1:0]  req_set;
  logic [TAG_W-1:0]   req_tag;
  logic               req_hit;
  logic [WAY_W-1:0]   hit_way;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] miss_total;

  logic                         in_take;
  logic                         out_free;
  logic                         commit;
  logic [ADDR_BITS-1:0]         addr_shifted;
  logic [ADDR_W-1:0]            in_set;
  logic [TAG_W-1:0]             in_tag;
  logic [ROW_W-1:0]             rd_row;
  logic [ROW_W-1:0]             wr_row;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [WAYS-1:0]              rd_valid;
  logic [WAYS-1:0][TAG_W-1:0]   rd_tags;
  logic [WAYS-1:0][AGE_W-1:0]   rd_ages;
  logic [WAYS-1:0]              new_valid;
  logic [WAYS-1:0][TAG_W-1:0]   new_tags;
  logic [WAYS-1:0][AGE_W-1:0]   new_ages;
  logic                         look_hit;
  logic [WAY_W-1:0]             look_way;
  logic                         scan_start;
  logic                         scan_done;
  logic [WAY_W-1:0]             victim;
  logic [WAY_W-1:0]             chosen;

  // Handshake: an item is taken only when no other item is in work.
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == ST_UPDATE) && out_free;

  // Split the address into set index and tag.
  assign addr_shifted = address >> OFF_W;
  assign in_set       = ADDR_W'(addr_shifted & SET_MASK);
  assign in_tag       = TAG_W'(address >> TAG_SHIFT);

  // Set RAM: read at acceptance, written by the clearing pass or at commit.
  assign wr_en   = (state == ST_CLEAR) || commit;
  assign wr_addr = (state == ST_CLEAR) ? clear_addr : req_set;
  assign wr_row  = (state == ST_CLEAR) ? '0 : {new_valid, new_tags, new_ages};

  sacl_set_ram #(
    .ADDR_W (ADDR_W),
    .ROW_W  (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (in_set),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  assign {rd_valid, rd_tags, rd_ages} = rd_row;

  // Tag compare across all ways; the lowest matching way is reported.
  always_comb begin
    look_hit = 1'b0;
    look_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w] && (rd_tags[w] == req_tag)) begin
        look_hit = 1'b1;
        look_way = WAY_W'(w);
      end
    end
  end

  // Victim search runs only on a miss.
  assign scan_start = (state == ST_LOOK) && !look_hit;

  sacl_victim_scan #(
    .WAYS (WAYS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .ages   (rd_ages),
    .done   (scan_done),
    .victim (victim)
  );

  assign chosen = req_hit ? hit_way : victim;

  // New row: the chosen way gets age zero (and the valid bit and the tag on a
  // miss); the other ways age by one, saturating.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_valid[w] = rd_valid[w];
      new_tags[w]  = rd_tags[w];
      if (WAY_W'(w) == chosen) begin
        new_ages[w] = '0;
        if (!req_hit) begin
          new_valid[w] = 1'b1;
          new_tags[w]  = req_tag;
        end
      end else begin
        new_ages[w] = rd_ages[w] + AGE_W'(rd_ages[w] != '1);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = look_hit ? ST_UPDATE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
        if (req_hit) begin
          hit_total <= hit_total + COUNT_W'(hit_total != '1);
        end else begin
          miss_total <= miss_total + COUNT_W'(miss_total != '1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_set <= in_set;
      req_tag <= in_tag;
    end
    if (state == ST_LOOK) begin
      req_hit <= look_hit;
      hit_way <= look_way;
    end
    if (commit) begin
      hit <= req_hit;
      way <= OUT_WAY_W'(chosen);
    end
  end

  // The totals only change at a commit, which waits for the held result.
  assign hit_count  = hit_total;
  assign miss_count = miss_total;

endmodule

FILE: sim/tb_set_assoc_cache_lru_lookup_core.sv
module tb_set_assoc_cache_lru_lookup_core;
  import sacl_pkg::*;

  // Geometry of the block under test; all sizes are powers of two.
  localparam int NUM_WAYS  = DEF_WAYS;
  localparam int NUM_SETS  = DEF_SETS;
  localparam int OFF_W     = $clog2(DEF_BLOCK_BYTES);
  localparam int IDX_W     = $clog2(DEF_SETS);
  localparam int TAG_W     = ADDR_BITS - OFF_W - IDX_W;
  localparam int RAND_ITEMS_PER_PHASE = 167;
  localparam int STUCK_LIMIT = 4000;
  localparam int DIR_ROWS  = 19;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
  } lookup_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    bit                   typed;
    lookup_t              want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_BITS-1:0] address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic [COUNT_W-1:0]   hit_count;
  logic [COUNT_W-1:0]   miss_count;

  // Shadow copy of the cache directory and the running totals.
  logic [TAG_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
  bit               line_valid [NUM_SETS][NUM_WAYS];
  logic [AGE_W-1:0] line_age   [NUM_SETS][NUM_WAYS];
  logic [COUNT_W-1:0] hit_tally;
  logic [COUNT_W-1:0] miss_tally;

  lookup_t  pending_lookups[$];
  dir_row_t dir_rows [DIR_ROWS];
  int       mismatches = 0;
  int       results_seen = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;

  set_assoc_cache_lru_lookup_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .way        (way),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  always #4 clk = ~clk;

  // Computes the outcome of one access and updates the shadow directory.
  function automatic void predict_lookup(input logic [ADDR_BITS-1:0] a, output lookup_t r);
    logic [IDX_W-1:0] set_i;
    logic [TAG_W-1:0] tag_v;
    logic [AGE_W-1:0] oldest;
    int               pick;
    bit               found;
    set_i = a[OFF_W +: IDX_W];
    tag_v = a[ADDR_BITS-1 -: TAG_W];
    found = 1'b0;
    pick  = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && line_valid[set_i][w] && line_tag[set_i][w] == tag_v) begin
        found = 1'b1;
        pick  = w;
      end
    end
    if (found) begin
      if (hit_tally != '1) hit_tally++;
    end else begin
      if (miss_tally != '1) miss_tally++;
      // The oldest way is refilled; the lowest way wins a tie.
      oldest = line_age[set_i][0];
      for (int w = 1; w < NUM_WAYS; w++) begin
        if (line_age[set_i][w] > oldest) begin
          oldest = line_age[set_i][w];
          pick   = w;
        end
      end
      line_tag[set_i][pick]   = tag_v;
      line_valid[set_i][pick] = 1'b1;
    end
    // The used way becomes youngest, the others age with saturation.
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w == pick) line_age[set_i][w] = '0;
      else if (line_age[set_i][w] != '1) line_age[set_i][w]++;
    end
    r.hit    = found;
    r.way    = pick[OUT_WAY_W-1:0];
    r.hits   = hit_tally;
    r.misses = miss_tally;
  endfunction

  // Mostly a few sets and a small pool of tags so that hits and evictions occur,
  // with some fully random addresses mixed in.
  function automatic logic [ADDR_BITS-1:0] rand_address();
    logic [TAG_W-1:0] tag_v;
    logic [IDX_W-1:0] set_v;
    logic [OFF_W-1:0] off_v;
    if ($urandom_range(99) < 15) return $urandom;
    tag_v = ($urandom_range(5) == 5) ? '1 : TAG_W'($urandom_range(4));
    set_v = ($urandom_range(4) == 0) ? '1 : IDX_W'($urandom_range(2));
    off_v = OFF_W'($urandom);
    return {tag_v, set_v, off_v};
  endfunction

  // Presents one item, waits for the handshake and records its expected result.
  task automatic send_address(input logic [ADDR_BITS-1:0] a, input bit typed,
                              input lookup_t want);
    lookup_t predicted;
    in_valid <= 1'b1;
    address  <= a;
    do @(posedge clk); while (in_stall);
    predict_lookup(a, predicted);
    pending_lookups.push_back(typed ? want : predicted);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // Receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_lookups.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_lookups.pop_front();
        if (want.hit !== hit || want.way !== way || want.hits !== hit_count ||
            want.misses !== miss_count) begin
          note_mismatch($sformatf(
            "result %0d: expected hit=%0b way=%0d hits=%0d misses=%0d, got hit=%0b way=%0d hits=%0d misses=%0d",
            results_seen, want.hit, want.way, want.hits, want.misses,
            hit, way, hit_count, miss_count));
        end
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Directed accesses: fresh sets, both ends of every field, fills and evictions.
    dir_rows = '{
      '{32'h0000_0000, 1'b1, '{1'b0, 2'd0, 40'd0, 40'd1}},
      '{32'h0000_003F, 1'b1, '{1'b1, 2'd0, 40'd1, 40'd1}},
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 40'd1, 40'd2}},
      '{32'hFFFF_FFC0, 1'b1, '{1'b1, 2'd0, 40'd2, 40'd2}},
      '{32'h0000_4000, 1'b0, '0},
      '{32'h0000_8000, 1'b0, '0},
      '{32'h0000_C000, 1'b0, '0},
      '{32'h0001_0000, 1'b0, '0},
      '{32'h0000_0000, 1'b0, '0},
      '{32'h0000_8010, 1'b0, '0},
      '{32'h0000_4000, 1'b0, '0},
      '{32'hFFFF_C000, 1'b0, '0},
      '{32'h0000_3FC0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h0000_0040, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0}
    };
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        line_age[s][w]   = '0;
      end
    end
    hit_tally  = '0;
    miss_tally = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Three phases: slow receiver, then slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 50 : 0;
      stall_pct = (phase == 0) ? 50 : (phase == 1) ? 29 : 0;
      if (phase == 0) begin
        for (int i = 0; i < DIR_ROWS; i++) begin
          send_address(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].want);
        end
      end
      for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++) begin
        send_address(rand_address(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for a late extra one.
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
